/* sv/bur_pkg.sv */
// ----------------------------------------------------------------------------
// bur_pkg: shared types and constants of the bounded uniform random block
// Generator constants, tempering and the front-to-back request record.
// ----------------------------------------------------------------------------
package bur_pkg;

  localparam int unsigned MtN       = 624;
  localparam int unsigned MtM       = 397;
  localparam int unsigned IdxW      = 10;
  localparam logic [31:0] MtMatrix  = 32'h9908_B0DF;
  localparam logic [31:0] MtInitMul = 32'd1812433253;
  localparam logic [31:0] SeedReset = 32'd5489;
  localparam int unsigned QDepth    = 2;

  typedef struct packed {
    logic [31:0] min_value;
    logic [31:0] size;
  } req_t;

  // Payload of the result channel.
  typedef struct packed {
    logic [31:0] random_value;
  } rsp_t;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & 32'h9D2C_5680);
    y = y ^ ((y << 15) & 32'hEFC6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

/* sv/bur_if.sv */
// ----------------------------------------------------------------------------
// bur_if: valid/ready channel
// Carries one payload of a parameterized type between a source and a sink.
// ----------------------------------------------------------------------------
interface bur_if #(
  parameter type T = logic [31:0]
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/bur_front.sv */
// ----------------------------------------------------------------------------
// bur_front: request intake
// Accepts requests, forms the span size and queues them for the back end.
// ----------------------------------------------------------------------------
module bur_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [31:0]  min_i,
  input  logic [31:0]  max_i,
  output logic         q_valid_o,
  input  logic         q_ready_i,
  output bur_pkg::req_t q_data_o
);
  import bur_pkg::*;

  req_t        mem_q [QDepth];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  assign in_ready_o = (cnt_q != 2'(QDepth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_data_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q].min_value <= min_i;
      mem_q[wp_q].size      <= max_i - min_i + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QDepth)) else $error("queue overflow");
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'(QDepth) |-> !in_ready_o) else $error("ready while full");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !q_valid_o) else $error("valid while empty");

endmodule

/* sv/bur_back.sv */
// ----------------------------------------------------------------------------
// bur_back: generator and bounded draw
// MT19937 table in a memory with seeding and twisting sequences, Lemire
// multiply-and-reject with a serial remainder unit for the threshold.
// ----------------------------------------------------------------------------
module bur_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          seed_we_i,
  input  logic [31:0]   seed_i,
  input  logic          q_valid_i,
  output logic          q_ready_o,
  input  bur_pkg::req_t q_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [31:0]   out_data_o
);
  import bur_pkg::*;

  localparam logic [3:0] StSeed  = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StTwR0  = 4'd2;
  localparam logic [3:0] StTwR1  = 4'd3;
  localparam logic [3:0] StTwR2  = 4'd4;
  localparam logic [3:0] StTwWr  = 4'd5;
  localparam logic [3:0] StRd    = 4'd6;
  localparam logic [3:0] StMul   = 4'd7;
  localparam logic [3:0] StChk   = 4'd8;
  localparam logic [3:0] StMod   = 4'd9;
  localparam logic [3:0] StOut   = 4'd10;
  localparam logic [3:0] StSeedM = 4'd11;
  localparam logic [3:0] StInit  = 4'd12;

  logic [31:0]     mem [MtN];
  logic [31:0]     rd_q;
  logic [IdxW-1:0] raddr;
  logic            wen;
  logic [IdxW-1:0] waddr;
  logic [31:0]     wdata;

  logic [3:0]      st_q;
  logic [IdxW-1:0] idx_q;     // next word / twist position / seed position
  logic [31:0]     prev_q;    // previous seed word, or word i during twist
  logic [31:0]     w1_q;      // word i+1 during twist
  logic [63:0]     prod_q;
  logic [31:0]     mul_q;     // seeding product
  logic            thr_ok_q;  // threshold known
  logic [31:0]     rem_q;
  logic [5:0]      bit_q;
  logic [31:0]     dvd_q;
  req_t            req_q;
  logic            ov_q;
  logic [31:0]     ores_q;
  logic [31:0]     res_q;     // finished value waiting for the output register

  function automatic logic [IdxW-1:0] wrap_add(input logic [IdxW-1:0] a,
                                               input logic [IdxW-1:0] b);
    logic [IdxW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IdxW+1)'(MtN)) s = s - (IdxW+1)'(MtN);
    return s[IdxW-1:0];
  endfunction

  always_comb begin
    raddr = idx_q;
    unique case (st_q)
      StTwR0:  raddr = idx_q;
      StTwR1:  raddr = wrap_add(idx_q, IdxW'(1));
      StTwR2:  raddr = wrap_add(idx_q, IdxW'(MtM));
      default: raddr = idx_q;
    endcase
  end

  // Twist and seed write data; a seed write always wins the port.
  logic [31:0] y_tw, v_tw;
  logic [32:0] rem_sh;
  always_comb begin
    y_tw = {prev_q[31], w1_q[30:0]};
    v_tw = rd_q ^ (y_tw >> 1) ^ (y_tw[0] ? MtMatrix : 32'd0);
    wen   = 1'b0;
    waddr = idx_q;
    wdata = v_tw;
    if (seed_we_i) begin
      wen   = 1'b1;
      waddr = '0;
      wdata = seed_i;
    end else if (st_q == StInit) begin
      wen   = 1'b1;
      waddr = '0;
      wdata = SeedReset;
    end else if (st_q == StTwWr) begin
      wen = 1'b1;
    end else if (st_q == StSeedM) begin
      wen   = 1'b1;
      wdata = mul_q + 32'(idx_q);
    end
    rem_sh = {rem_q, dvd_q[31]};
  end

  always_ff @(posedge clk_i) begin
    if (wen) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  assign q_ready_o   = (st_q == StIdle) && !seed_we_i;
  assign out_valid_o = ov_q;
  assign out_data_o  = ores_q;

  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o) req_q <= q_data_i;
    if (seed_we_i) prev_q <= seed_i;
    else if (st_q == StInit) prev_q <= SeedReset;
    else if (st_q == StSeedM) prev_q <= wdata;
    else if (st_q == StTwR1) prev_q <= rd_q;
    if (st_q == StTwR2) w1_q <= rd_q;
    if (st_q == StSeed) mul_q <= MtInitMul * (prev_q ^ (prev_q >> 30));
    // The full span would multiply by zero, so the raw word is kept instead.
    if (st_q == StMul) begin
      if (req_q.size == 32'd0) prod_q <= 64'(temper(rd_q));
      else prod_q <= 64'(temper(rd_q)) * 64'(req_q.size);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StInit;
      idx_q    <= IdxW'(1);
      thr_ok_q <= 1'b0;
      rem_q    <= '0;
      bit_q    <= '0;
      dvd_q    <= '0;
      ov_q     <= 1'b0;
      ores_q   <= '0;
      res_q    <= '0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      if (seed_we_i) begin
        st_q  <= StSeed;
        idx_q <= IdxW'(1);
      end else begin
        unique case (st_q)
          StInit:  st_q <= StSeed;
          StSeed:  st_q <= StSeedM;
          StSeedM: begin
            if (idx_q == IdxW'(MtN - 1)) begin
              st_q  <= StIdle;
              idx_q <= IdxW'(MtN);
            end else begin
              idx_q <= idx_q + IdxW'(1);
              st_q  <= StSeed;
            end
          end
          StIdle: begin
            if (q_valid_i) begin
              thr_ok_q <= 1'b0;
              if (idx_q == IdxW'(MtN)) begin
                idx_q <= '0;
                st_q  <= StTwR0;
              end else begin
                st_q <= StRd;
              end
            end
          end
          StTwR0: st_q <= StTwR1;
          StTwR1: st_q <= StTwR2;
          StTwR2: st_q <= StTwWr;
          StTwWr: begin
            if (idx_q == IdxW'(MtN - 1)) begin
              idx_q <= '0;
              st_q  <= StRd;
            end else begin
              idx_q <= idx_q + IdxW'(1);
              st_q  <= StTwR0;
            end
          end
          StRd: st_q <= StMul;
          StMul: begin
            idx_q <= idx_q + IdxW'(1);
            st_q  <= StChk;
          end
          StChk: begin
            if (req_q.size == 32'd0) begin
              res_q <= prod_q[31:0] + req_q.min_value;  // raw word
              st_q  <= StOut;
            end else if (prod_q[31:0] >= req_q.size) begin
              res_q <= prod_q[63:32] + req_q.min_value;
              st_q  <= StOut;
            end else if (!thr_ok_q) begin
              rem_q <= '0;
              dvd_q <= 32'd0 - req_q.size;
              bit_q <= '0;
              st_q  <= StMod;
            end else if (prod_q[31:0] >= rem_q) begin
              res_q <= prod_q[63:32] + req_q.min_value;
              st_q  <= StOut;
            end else if (idx_q == IdxW'(MtN)) begin
              idx_q <= '0;
              st_q  <= StTwR0;
            end else begin
              st_q <= StRd;
            end
          end
          StMod: begin
            dvd_q <= dvd_q << 1;
            if (rem_sh >= {1'b0, req_q.size}) rem_q <= 32'(rem_sh - {1'b0, req_q.size});
            else rem_q <= rem_sh[31:0];
            bit_q <= bit_q + 6'd1;
            if (bit_q == 6'd31) begin
              thr_ok_q <= 1'b1;
              st_q     <= StChk;
            end
          end
          StOut: begin
            if (!ov_q) begin
              ov_q   <= 1'b1;
              ores_q <= res_q;
              st_q   <= StIdle;
            end
          end
          default: st_q <= StIdle;
        endcase
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(ores_q)) else $error("result lost");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IdxW'(MtN)) else $error("index out of range");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ready_o |-> st_q == StIdle) else $error("accept while busy");

endmodule

/* sv/bounded_uniform_random.sv */
// ----------------------------------------------------------------------------
// bounded_uniform_random: uniform integer in a requested span
// Lemire multiply-and-reject over MT19937 words, APB seed register.
// ----------------------------------------------------------------------------
// Each item carries an inclusive minimum and maximum; one uniform value in
// that span comes back per item. The span size wraps modulo 2^32, and the
// full 32-bit span returns the raw tempered word plus the minimum. A draw
// in the current table reads, multiplies and checks one word; when the
// table index reaches 624 a twist runs first (once per 624 words), reading
// words i, i+1 and i+397 through the single read port, then writing word i.
// A low half below the size starts a serial remainder for the threshold;
// one below that threshold is redrawn. After reset and each write of
// seed_value (byte address 0) the seeding sequence fills the 624-word table
// and no item is taken meanwhile; requests queue two deep before the back end.
module bounded_uniform_random (
  input  logic        clk_i,
  input  logic        rst_ni,
  bur_if.sink         req_i,
  bur_if.source       rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bur_pkg::*;

  logic        seed_we;
  logic [31:0] seed_q;
  logic        qv, qr;
  req_t        qd;

  assign pready  = 1'b1;
  // Register 0 lives at address 0; other addresses are ignored.
  assign seed_we = psel && penable && pwrite && (paddr == 2'd0);
  assign prdata  = (paddr == 2'd0) ? seed_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seed_q <= SeedReset;
    else if (seed_we) seed_q <= pwdata;
  end

  bur_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .min_i      (req_i.data.min_value),
    .max_i      (req_i.data.max_value),
    .q_valid_o  (qv),
    .q_ready_i  (qr),
    .q_data_o   (qd)
  );

  bur_back u_back (
    .clk_i, .rst_ni,
    .seed_we_i   (seed_we),
    .seed_i      (pwdata),
    .q_valid_i   (qv),
    .q_ready_o   (qr),
    .q_data_i    (qd),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_data_o  (rsp_o.data.random_value)
  );

endmodule
